### design/sbs_pkg.sv
// Shared types and constants for the sorted table binary search unit.
// Operation and status codes, search sequencer states, result bundle.
// No dependencies.
package sbs_pkg;

	// Fixed field widths of the item and result beats
	localparam int unsigned OP_BITS     = 2;
	localparam int unsigned VALUE_BITS  = 32;
	localparam int unsigned STATUS_BITS = 3;
	localparam int unsigned POS_BITS    = 10;

	typedef enum logic [OP_BITS-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK        = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_ORDER     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SRCH_IDLE,
		SRCH_PROBE,
		SRCH_CMP,
		SRCH_HOLD
	} srch_state_t;

	// Finished search result handed to the output register
	typedef struct packed {
		logic                valid;
		status_t             status;
		logic [POS_BITS-1:0] position;
	} sbs_result_t;

endpackage

### design/sbs_table_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
// Uses sbs_pkg only for the common import convention.
module sbs_table_ram
	import sbs_pkg::*;
#(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32,
	localparam int unsigned IDX_BITS = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [IDX_BITS-1:0]         wr_addr,
	input  logic signed [WORD_BITS-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [IDX_BITS-1:0]         rd_addr,
	output logic signed [WORD_BITS-1:0] rd_data
);

	logic signed [WORD_BITS-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, read data registered from the address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/sbs_search_seq.sv
// Binary search sequencer: keeps the live range, issues one probe address,
// compares the returned word with the key. Depends on sbs_pkg.
module sbs_search_seq
	import sbs_pkg::*;
#(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32,
	localparam int unsigned IDX_BITS = $clog2(DEPTH),
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] key,
	input  logic [CNT_BITS-1:0]         count,
	output logic                        busy,
	output logic                        rd_en,
	output logic [IDX_BITS-1:0]         rd_addr,
	input  logic signed [WORD_BITS-1:0] rd_data,
	output sbs_result_t                 result,
	input  logic                        take
);

	srch_state_t state_q, state_d;

	logic [CNT_BITS-1:0]         lo_q;
	logic [CNT_BITS-1:0]         hi_q;   // exclusive upper bound
	logic [IDX_BITS-1:0]         mid_q;
	logic signed [WORD_BITS-1:0] key_q;
	logic                        found_q;

	logic [CNT_BITS:0]   mid_sum;
	logic [IDX_BITS-1:0] mid_w;
	logic                empty_w;
	logic                hit_w;

	// midpoint: floor((lo + hi_incl) / 2), never above DEPTH-1
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CNT_BITS{1'b0}}, 1'b1};
	assign mid_w   = IDX_BITS'(mid_sum >> 1);
	assign empty_w = (lo_q >= hi_q);
	assign hit_w   = (rd_data == key_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SRCH_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory read request
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		unique case (state_q)
			SRCH_IDLE: begin
				if (start) begin
					state_d = SRCH_PROBE;
				end
			end
			SRCH_PROBE: begin
				if (empty_w) begin
					state_d = SRCH_HOLD;
				end else begin
					rd_en   = 1'b1;
					state_d = SRCH_CMP;
				end
			end
			SRCH_CMP: begin
				if (hit_w) begin
					state_d = SRCH_HOLD;
				end else begin
					state_d = SRCH_PROBE;
				end
			end
			SRCH_HOLD: begin
				if (take) begin
					state_d = SRCH_IDLE;
				end
			end
			default: state_d = SRCH_IDLE;
		endcase
	end

	assign rd_addr = mid_w;
	assign busy    = (state_q != SRCH_IDLE);

	// range bookkeeping
	always_ff @(posedge clk) begin
		if (state_q == SRCH_IDLE && start) begin
			lo_q  <= '0;
			hi_q  <= count;
			key_q <= key;
		end
		if (state_q == SRCH_PROBE) begin
			mid_q   <= mid_w;
			found_q <= 1'b0;
		end
		if (state_q == SRCH_CMP) begin
			if (hit_w) begin
				found_q <= 1'b1;
			end else if (rd_data < key_q) begin
				lo_q <= CNT_BITS'(mid_q) + CNT_BITS'(1);
			end else begin
				hi_q <= CNT_BITS'(mid_q);
			end
		end
	end

	// finished result
	always_comb begin
		result.valid    = (state_q == SRCH_HOLD);
		result.status   = found_q ? ST_FOUND : ST_NOT_FOUND;
		result.position = found_q ? POS_BITS'(mid_q) : '0;
	end

endmodule

### design/sorted_table_binary_search_unit.sv
// Top level of the sorted table binary search unit: input handshake, entry
// count, append checks, output register. Depends on sbs_pkg, sbs_table_ram,
// sbs_search_seq.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  operation, value
//   output   out        out_valid / out_stall status, position
//
// Clear and append go from the accepted beat straight into the output register.
// A search makes P probes (at most 11 for 1024 entries): each probe is one table
// read on the single read port and one compare with the key. A hit ends the
// search at its compare; a miss ends once the live range is empty.
// Reset clears the entry count and all control; table contents are kept as
// don't-care. A new beat is taken once no search runs and the output register
// is empty or being drained, so a stalled result holds off the input.
module sorted_table_binary_search_unit
	import sbs_pkg::*;
#(
	parameter int unsigned DEPTH     = 1024,
	parameter int unsigned WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [OP_BITS-1:0]           operation,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [STATUS_BITS-1:0]       status,
	output logic [POS_BITS-1:0]          position
);

	localparam int unsigned IDX_BITS = $clog2(DEPTH);
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

	logic [CNT_BITS-1:0]         count_q;
	logic signed [WORD_BITS-1:0] last_q;
	logic                        out_valid_q;
	status_t                     status_q;
	logic [POS_BITS-1:0]         position_q;

	logic                        accept;
	logic                        slot_free;
	logic                        srch_busy;
	logic                        srch_start;
	logic                        srch_take;
	logic                        imm_load;
	logic                        wr_en;
	status_t                     imm_status;
	logic signed [WORD_BITS-1:0] word;
	logic                        rd_en;
	logic [IDX_BITS-1:0]         rd_addr;
	logic signed [WORD_BITS-1:0] rd_data;
	sbs_result_t                 srch_res;

	// wrap the 32-bit two's complement value to the table word width
	assign word = WORD_BITS'(value);

	assign slot_free  = !out_valid_q || !out_stall;
	assign in_stall   = srch_busy || !slot_free;
	assign accept     = in_valid && !in_stall;
	assign srch_start = accept && (operation == OP_SEARCH);
	assign imm_load   = accept && (operation != OP_SEARCH);
	assign srch_take  = srch_res.valid && slot_free;

	// clear and append decode; full check comes before order check
	always_comb begin
		wr_en      = 1'b0;
		imm_status = ST_OK;
		unique case (op_t'(operation))
			OP_APPEND: begin
				if (count_q == CNT_BITS'(DEPTH)) begin
					imm_status = ST_FULL;
				end else if (count_q != '0 && word < last_q) begin
					imm_status = ST_ORDER;
				end else begin
					wr_en = accept;
				end
			end
			OP_CLEAR:  imm_status = ST_OK;
			OP_SEARCH: imm_status = ST_OK;
			default:   imm_status = ST_OK;
		endcase
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && operation == OP_CLEAR) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_BITS'(1);
		end
	end

	// copy of the last entry for the order check
	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_q <= word;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (imm_load || srch_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (imm_load) begin
			status_q   <= imm_status;
			position_q <= '0;
		end else if (srch_take) begin
			status_q   <= srch_res.status;
			position_q <= srch_res.position;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;

	sbs_table_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_BITS'(count_q)),
		.wr_data (word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sbs_search_seq #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (srch_start),
		.key     (word),
		.count   (count_q),
		.busy    (srch_busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.result  (srch_res),
		.take    (srch_take)
	);

endmodule
